// ===== sv/trd_pkg.sv =====
`default_nettype none

package trd_pkg;

    localparam int KEY_COUNT  = 4;
    localparam int KEY_MASK_W = 4;
    localparam int REG_COUNT  = 8;
    localparam int REG_IDX_W  = 3;
    localparam int BAND_W     = 10;
    localparam int COORD_W    = 10;
    localparam int COUNT_W    = 3;

    // finger count that the controller uses for "no valid second finger"
    localparam logic [COUNT_W-1:0] COUNT_INVALID = 3'd7;

    localparam logic [BAND_W-1:0] BAND_RESET [REG_COUNT] = '{
        10'd1, 10'd30, 10'd60, 10'd120, 10'd200, 10'd250, 10'd295, 10'd315
    };

    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] index;
        logic [BAND_W-1:0]    data;
    } cfg_wr_t;

    // two position bytes packed as hi, lo -> 10-bit coordinate
    function automatic logic [COORD_W-1:0] coord_from(input logic [15:0] bytes);
        coord_from = {bytes[9:8], bytes[7:0]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/trd_keys.sv =====
`default_nettype none

module trd_keys
    import trd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_wr_t               cfg,
    input  wire logic                  step,
    input  wire logic [BAND_W-1:0]     keypos,
    output logic      [KEY_MASK_W-1:0] down_next,
    output logic      [KEY_MASK_W-1:0] change
);

    logic [BAND_W-1:0]     band_reg [REG_COUNT];
    logic [KEY_MASK_W-1:0] pressed_reg;
    logic [KEY_MASK_W-1:0] in_band;
    logic [KEY_MASK_W-1:0] diff;
    logic [KEY_MASK_W-1:0] pick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                band_reg[i] <= BAND_RESET[i];
            end
        end
        else if (cfg.we)
        begin
            band_reg[cfg.index] <= cfg.data;
        end
    end

    always_comb
    begin
        in_band = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            in_band[k] = (keypos >= band_reg[2*k]) && (keypos <= band_reg[2*k+1]);
        end
    end

    // the first key whose flag disagrees with its band toggles
    assign diff = in_band ^ pressed_reg;
    assign pick = diff & (~diff + 1'b1);

    always_comb
    begin
        if (keypos == '0)
        begin
            down_next = '0;
        end
        else
        begin
            down_next = pressed_reg ^ pick;
        end
    end

    assign change = pressed_reg ^ down_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= '0;
        end
        else if (step)
        begin
            pressed_reg <= down_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/touch_report_decoder_with_keys.sv =====
`default_nettype none

// Decodes one raw touch report per cycle while out_stall is low: finger
// count, first finger X/Y, pressure and width, the second finger X/Y (zero
// unless the count is 2..6), and a 10-bit key strip position that drives
// four virtual keys with writable bands (write only while no word is in
// flight). A word is taken into an input register, decoded and held in a
// result register, so one word per cycle flows through while out_stall is
// low; the key pressed flags update as each word enters the result register.
module touch_report_decoder_with_keys
    import trd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [BAND_W-1:0]     cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            status_byte,
    input  wire logic [31:0]           first_pos_bytes,
    input  wire logic [7:0]            pressure_byte,
    input  wire logic [7:0]            width_byte,
    input  wire logic [7:0]            key_low_byte,
    input  wire logic [7:0]            key_high_byte,
    input  wire logic [31:0]           second_pos_bytes,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [COUNT_W-1:0]         finger_count,
    output logic [COORD_W-1:0]         x_first,
    output logic [COORD_W-1:0]         y_first,
    output logic [7:0]                 pressure,
    output logic [7:0]                 width,
    output logic                       second_down,
    output logic [COORD_W-1:0]         x_second,
    output logic [COORD_W-1:0]         y_second,
    output logic [KEY_MASK_W-1:0]      key_down_mask,
    output logic [KEY_MASK_W-1:0]      key_change_mask
);

    logic                  s1_valid_reg;
    logic [COUNT_W-1:0]    s1_count_reg;
    logic [31:0]           s1_first_reg;
    logic [7:0]            s1_pressure_reg;
    logic [7:0]            s1_width_reg;
    logic [BAND_W-1:0]     s1_keypos_reg;
    logic [31:0]           s1_second_reg;

    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COORD_W-1:0]    x_first_reg;
    logic [COORD_W-1:0]    y_first_reg;
    logic [7:0]            pressure_reg;
    logic [7:0]            width_reg;
    logic                  second_reg;
    logic [COORD_W-1:0]    x_second_reg;
    logic [COORD_W-1:0]    y_second_reg;
    logic [KEY_MASK_W-1:0] down_reg;
    logic [KEY_MASK_W-1:0] change_reg;

    logic                  out_ready;
    logic                  advance;
    logic                  in_take;
    logic                  second_next;
    logic [KEY_MASK_W-1:0] down_next;
    logic [KEY_MASK_W-1:0] change_next;
    cfg_wr_t               cfg;

    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_count_reg    <= status_byte[COUNT_W-1:0];
            s1_first_reg    <= first_pos_bytes;
            s1_pressure_reg <= pressure_byte;
            s1_width_reg    <= width_byte;
            s1_keypos_reg   <= {key_high_byte[4:3], key_low_byte};
            s1_second_reg   <= second_pos_bytes;
        end
    end

    assign second_next = (s1_count_reg > 3'd1) && (s1_count_reg != COUNT_INVALID);

    trd_keys u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .keypos    (s1_keypos_reg),
        .down_next (down_next),
        .change    (change_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_reg    <= s1_count_reg;
            x_first_reg  <= coord_from(s1_first_reg[31:16]);
            y_first_reg  <= coord_from(s1_first_reg[15:0]);
            pressure_reg <= s1_pressure_reg;
            width_reg    <= s1_width_reg;
            second_reg   <= second_next;
            x_second_reg <= second_next ? coord_from(s1_second_reg[31:16]) : '0;
            y_second_reg <= second_next ? coord_from(s1_second_reg[15:0]) : '0;
            down_reg     <= down_next;
            change_reg   <= change_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign finger_count    = count_reg;
    assign x_first         = x_first_reg;
    assign y_first         = y_first_reg;
    assign pressure        = pressure_reg;
    assign width           = width_reg;
    assign second_down     = second_reg;
    assign x_second        = x_second_reg;
    assign y_second        = y_second_reg;
    assign key_down_mask   = down_reg;
    assign key_change_mask = change_reg;

endmodule

`default_nettype wire

// ===== sv/trd_checker.sv =====
`default_nettype none

module trd_checker
    import trd_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [COUNT_W-1:0]    finger_count,
    input wire logic                  second_down,
    input wire logic [COORD_W-1:0]    x_second,
    input wire logic [COORD_W-1:0]    y_second,
    input wire logic [KEY_MASK_W-1:0] key_change_mask
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // at most one key toggles per word, zero releases all; checked as <= KEY_COUNT
    a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ($countones(key_change_mask) > 1) |->
            ($countones(key_change_mask) <= KEY_COUNT))
        else $error("key change mask wider than key count");

    a_second_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_down == ((finger_count > 3'd1) &&
                                       (finger_count != COUNT_INVALID))))
        else $error("second finger flag disagrees with count");

    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !second_down |-> (x_second == '0) && (y_second == '0))
        else $error("second finger coordinates set without second finger");

endmodule

bind touch_report_decoder_with_keys trd_checker u_trd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .finger_count    (finger_count),
    .second_down     (second_down),
    .x_second        (x_second),
    .y_second        (y_second),
    .key_change_mask (key_change_mask)
);

`default_nettype wire

// ===== test/touch_report_decoder_with_keys_test.sv =====
`default_nettype none

module touch_report_decoder_with_keys_test;
    import trd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_WAIT = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        KEY0_LOW, KEY0_HIGH, KEY1_LOW, KEY1_HIGH,
        KEY2_LOW, KEY2_HIGH, KEY3_LOW, KEY3_HIGH
    } band_reg_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [31:0] first_pos;
        logic [7:0]  pressure;
        logic [7:0]  tool_width;
        logic [7:0]  key_lo;
        logic [7:0]  key_hi;
        logic [31:0] second_pos;
    } report_t;

    typedef struct packed {
        logic [COUNT_W-1:0]    finger_count;
        logic [COORD_W-1:0]    x_first;
        logic [COORD_W-1:0]    y_first;
        logic [7:0]            pressure;
        logic [7:0]            width;
        logic                  second_down;
        logic [COORD_W-1:0]    x_second;
        logic [COORD_W-1:0]    y_second;
        logic [KEY_MASK_W-1:0] key_down_mask;
        logic [KEY_MASK_W-1:0] key_change_mask;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [BAND_W-1:0]    cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  status_byte = '0;
    logic [31:0] first_pos_bytes = '0;
    logic [7:0]  pressure_byte = '0;
    logic [7:0]  width_byte = '0;
    logic [7:0]  key_low_byte = '0;
    logic [7:0]  key_high_byte = '0;
    logic [31:0] second_pos_bytes = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COUNT_W-1:0]    finger_count;
    logic [COORD_W-1:0]    x_first;
    logic [COORD_W-1:0]    y_first;
    logic [7:0]            pressure;
    logic [7:0]            width;
    logic                  second_down;
    logic [COORD_W-1:0]    x_second;
    logic [COORD_W-1:0]    y_second;
    logic [KEY_MASK_W-1:0] key_down_mask;
    logic [KEY_MASK_W-1:0] key_change_mask;

    // predictor state: band registers and pressed flags as the block should hold them
    logic [BAND_W-1:0]     bands [REG_COUNT];
    logic [KEY_MASK_W-1:0] keys_held = '0;

    report_t  pending_reports [$];
    decoded_t expected_reports [$];
    report_t  cur_report;

    int reports_queued = 0;
    int reports_accepted = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    logic [15:0] stall_cycle = '0;

    touch_report_decoder_with_keys i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .status_byte      (status_byte),
        .first_pos_bytes  (first_pos_bytes),
        .pressure_byte    (pressure_byte),
        .width_byte       (width_byte),
        .key_low_byte     (key_low_byte),
        .key_high_byte    (key_high_byte),
        .second_pos_bytes (second_pos_bytes),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .finger_count     (finger_count),
        .x_first          (x_first),
        .y_first          (y_first),
        .pressure         (pressure),
        .width            (width),
        .second_down      (second_down),
        .x_second         (x_second),
        .y_second         (y_second),
        .key_down_mask    (key_down_mask),
        .key_change_mask  (key_change_mask)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decodes one report and advances the pressed flags
    function automatic decoded_t decode_report(input report_t r);
        decoded_t d;
        logic [BAND_W-1:0] pos;
        logic [KEY_MASK_W-1:0] prior;
        logic in_band;
        logic done;
        d.finger_count = r.status[COUNT_W-1:0];
        d.x_first = {r.first_pos[25:24], r.first_pos[23:16]};
        d.y_first = {r.first_pos[9:8], r.first_pos[7:0]};
        d.pressure = r.pressure;
        d.width = r.tool_width;
        d.second_down = (d.finger_count > 3'd1) && (d.finger_count != COUNT_INVALID);
        d.x_second = d.second_down ? {r.second_pos[25:24], r.second_pos[23:16]} : '0;
        d.y_second = d.second_down ? {r.second_pos[9:8], r.second_pos[7:0]} : '0;
        pos = {r.key_hi[4:3], r.key_lo};
        prior = keys_held;
        if (pos == '0)
        begin
            keys_held = '0;
        end
        else
        begin
            done = 1'b0;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                if (!done)
                begin
                    in_band = (pos >= bands[2*k]) && (pos <= bands[2*k+1]);
                    if (in_band && !keys_held[k])
                    begin
                        keys_held[k] = 1'b1;
                        done = 1'b1;
                    end
                    else if (!in_band && keys_held[k])
                    begin
                        keys_held[k] = 1'b0;
                        done = 1'b1;
                    end
                end
            end
        end
        d.key_down_mask = keys_held;
        d.key_change_mask = prior ^ keys_held;
        return d;
    endfunction

    task automatic queue_report(input logic [7:0] st, input logic [31:0] p1,
                                input logic [7:0] pr, input logic [7:0] wd,
                                input logic [BAND_W-1:0] pos, input logic [7:0] hi_noise,
                                input logic [31:0] p2);
        report_t r;
        r.status = st;
        r.first_pos = p1;
        r.pressure = pr;
        r.tool_width = wd;
        r.key_lo = pos[7:0];
        r.key_hi = (hi_noise & 8'he7) | {3'b000, pos[9:8], 3'b000};
        r.second_pos = p2;
        pending_reports.push_back(r);
        reports_queued++;
    endtask

    task automatic queue_random_reports(input int n);
        logic [BAND_W-1:0] pos;
        logic [BAND_W-1:0] last_pos;
        logic [BAND_W-1:0] lo;
        logic [BAND_W-1:0] hi;
        int k;
        int pick;
        last_pos = '0;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, KEY_COUNT - 1);
            lo = bands[2*k];
            hi = bands[2*k+1];
            if (pick < 10)
                pos = '0;
            else if (pick < 25)
                pos = last_pos;
            else if (pick < 60)
                pos = (lo <= hi) ? BAND_W'($urandom_range(lo, hi)) : BAND_W'($urandom);
            else if (pick < 82)
            begin
                case ($urandom_range(0, 3))
                    0: pos = lo;
                    1: pos = hi;
                    2: pos = lo - 1'b1;
                    default: pos = hi + 1'b1;
                endcase
            end
            else
                pos = BAND_W'($urandom);
            last_pos = pos;
            queue_report(8'($urandom), $urandom, 8'($urandom), 8'($urandom),
                         pos, 8'($urandom), $urandom);
        end
    endtask

    // waits until every queued word has come back and the pipeline is empty
    task automatic wait_drained();
        while (reports_accepted != reports_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic load_bands(input logic [REG_COUNT*BAND_W-1:0] v);
        band_reg_t idx;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            idx = band_reg_t'(i);
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= v[(REG_COUNT-1-i)*BAND_W +: BAND_W];
            bands[i] = v[(REG_COUNT-1-i)*BAND_W +: BAND_W];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // sender: bursts of words with random gaps in between
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_reports.push_back(decode_report(cur_report));
                reports_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reports.size() > 0)
                begin
                    cur_report = pending_reports.pop_front();
                    status_byte <= cur_report.status;
                    first_pos_bytes <= cur_report.first_pos;
                    pressure_byte <= cur_report.pressure;
                    width_byte <= cur_report.tool_width;
                    key_low_byte <= cur_report.key_lo;
                    key_high_byte <= cur_report.key_hi;
                    second_pos_bytes <= cur_report.second_pos;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        if ($urandom_range(0, 15) == 0)
                            gap_left = $urandom_range(9, 30);
                        else if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: cycles through no stall, sparse, periodic and heavy stalling
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[8:7])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 2) == 0);
            2'd2: out_stall <= (stall_cycle[2:0] < 3'd3);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        decoded_t got;
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {finger_count, x_first, y_first, pressure, width, second_down,
                   x_second, y_second, key_down_mask, key_change_mask};
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word at %0t", $time);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result word at %0t (exp/got): cnt %0d/%0d x1 %0d/%0d ",
                                  "y1 %0d/%0d pr %0d/%0d wd %0d/%0d 2nd %0d/%0d ",
                                  "x2 %0d/%0d y2 %0d/%0d down %h/%h chg %h/%h"},
                                 $time, want.finger_count, got.finger_count,
                                 want.x_first, got.x_first, want.y_first, got.y_first,
                                 want.pressure, got.pressure, want.width, got.width,
                                 want.second_down, got.second_down,
                                 want.x_second, got.x_second, want.y_second, got.y_second,
                                 want.key_down_mask, got.key_down_mask,
                                 want.key_change_mask, got.key_change_mask);
                end
            end
        end
    end

    // watchdog on cycles in which no word moves on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [REG_COUNT*BAND_W-1:0] rnd_bands;
        logic [BAND_W-1:0] a;
        logic [BAND_W-1:0] b;
        foreach (bands[i])
            bands[i] = BAND_RESET[i];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset bands: key0 1..30, key1 60..120, key2 200..250, key3 295..315
        queue_report(8'h00, 32'h0000_0000, 8'h00, 8'h00, 10'd0, 8'h00, 32'h0000_0000);
        queue_report(8'hff, 32'hffff_ffff, 8'hff, 8'hff, 10'd1023, 8'hff, 32'hffff_ffff);
        queue_report(8'h01, 32'h0312_0245, 8'h10, 8'h20, 10'd1, 8'h00, 32'h0101_0101);
        queue_report(8'h02, 32'h0280_01ff, 8'h80, 8'h01, 10'd30, 8'h00, 32'h03ff_03ff);
        queue_report(8'h03, 32'hfc00_fc00, 8'h7f, 8'hfe, 10'd31, 8'h00, 32'h0200_0155);
        queue_report(8'h04, 32'h0155_02aa, 8'h01, 8'h80, 10'd60, 8'h00, 32'hfeff_fdff);
        queue_report(8'h05, 32'h00ff_0000, 8'h55, 8'haa, 10'd120, 8'h00, 32'h0000_0000);
        queue_report(8'h06, 32'haaaa_5555, 8'haa, 8'h55, 10'd121, 8'h00, 32'h5555_aaaa);
        queue_report(8'h07, 32'h0101_0101, 8'h33, 8'hcc, 10'd15, 8'h00, 32'h0312_0345);
        queue_report(8'h01, 32'h0000_0000, 8'h00, 8'h00, 10'd200, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd200, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd300, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd300, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd315, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd316, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd295, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd10, 8'h00, 32'h0000_0000);
        queue_report(8'h02, 32'h0000_0000, 8'h00, 8'h00, 10'd0, 8'hff, 32'h0000_0000);
        queue_report(8'hfe, 32'h0000_0000, 8'h00, 8'h00, 10'd1000, 8'he7, 32'h0000_0000);
        queue_report(8'hf8, 32'h0000_0000, 8'h00, 8'h00, 10'd256, 8'h00, 32'h0000_0000);
        queue_random_reports(100);
        wait_drained();

        // every key covers the whole strip
        load_bands({10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023});
        queue_random_reports(90);
        wait_drained();

        // single-point bands at 0, 1023, 1 and 512
        load_bands({10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1, 10'd1, 10'd512, 10'd512});
        queue_random_reports(90);
        wait_drained();

        // inverted and overlapping bands
        load_bands({10'd1023, 10'd0, 10'd5, 10'd3, 10'd100, 10'd400, 10'd300, 10'd350});
        queue_random_reports(110);
        wait_drained();

        repeat (2)
        begin
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                a = BAND_W'($urandom);
                b = BAND_W'($urandom);
                if ($urandom_range(0, 3) != 0 && a > b)
                    rnd_bands[(REG_COUNT-2*k)*BAND_W-1 -: 2*BAND_W] = {b, a};
                else
                    rnd_bands[(REG_COUNT-2*k)*BAND_W-1 -: 2*BAND_W] = {a, b};
            end
            load_bands(rnd_bands);
            queue_random_reports(110);
            wait_drained();
        end

        // back to the reset bands, written explicitly
        load_bands({10'd1, 10'd30, 10'd60, 10'd120, 10'd200, 10'd250, 10'd295, 10'd315});
        queue_random_reports(60);
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
